### hdl/dls_pkg.sv
// shared types, constants, lfsr feedback and popcount helper functions for the dual lfsr scrambler
// no dependencies
package dls_pkg;

    localparam int LFSR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int TOTAL_W   = 32;
    localparam int POP_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = LFSR_W;

    typedef logic [LFSR_W-1:0]  lfsr_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [POP_W-1:0]   pop_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED_A = 1'b0,
        REG_SEED_B = 1'b1
    } cfg_reg_t;

    localparam lfsr_t SEED_RESET = lfsr_t'(1);

    // taps 6,1
    function automatic logic fb_a(input lfsr_t s);
        return s[6] ^ s[1];
    endfunction

    // taps 6,5,2,1
    function automatic logic fb_b(input lfsr_t s);
        return s[6] ^ s[5] ^ s[2] ^ s[1];
    endfunction

    function automatic pop_t popcount8(input byte_t v);
        pop_t n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + pop_t'(v[i]);
        end
        return n;
    endfunction

endpackage

### hdl/dls_in_if.sv
// valid/ready channel carrying one plain byte and the restart flag
// depends on dls_pkg
interface dls_in_if
    import dls_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

### hdl/dls_out_if.sv
// valid/ready channel carrying one scrambled byte and the running totals
// depends on dls_pkg
interface dls_out_if
    import dls_pkg::*;
();
    logic   valid;
    logic   ready;
    byte_t  scrambled_byte;
    total_t ones_in_total;
    total_t ones_out_total;
    total_t bits_total;

    modport source (output valid, output scrambled_byte, output ones_in_total,
                    output ones_out_total, output bits_total, input ready);
    modport sink   (input valid, input scrambled_byte, input ones_in_total,
                    input ones_out_total, input bits_total, output ready);
endinterface

### hdl/dual_lfsr_stream_scrambler.sv
// top level of the dual lfsr stream scrambler: input register, keystream, counters,
// result register; depends on dls_pkg, dls_in_if, dls_out_if, dls_keystream, dls_sat_counter
//
// Takes one byte per clock and returns one scrambled byte per byte, in order, through
// the input register and then the result register; the eight lfsr steps of a byte
// are one pass of xor logic between them, so a transfer can follow in every cycle as
// long as the sink keeps ready high. Bit 0 of each byte is scrambled first.
// Setting restart on a byte reloads both lfsrs from seed_a / seed_b and clears the
// three totals before that byte. The user must write seeds through cfg_we/cfg_index/cfg_data
// only while no byte is in flight; the block does not enforce this. They take effect at
// the next restart; both reset to 1. Totals saturate at 2^COUNT_WIDTH-1, all ones above 32 bits.
module dual_lfsr_stream_scrambler
    import dls_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dls_in_if.sink               plain,
    dls_out_if.source            scrambled,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lfsr_t  seed_a_reg;
    lfsr_t  seed_b_reg;
    lfsr_t  shift_a_reg;
    lfsr_t  shift_b_reg;

    logic   in_valid_reg;
    byte_t  data_reg;
    logic   restart_reg;

    logic   out_valid_reg;
    byte_t  scr_reg;
    total_t ones_in_reg;
    total_t ones_out_reg;
    total_t bits_reg;

    logic   advance;
    lfsr_t  start_a;
    lfsr_t  start_b;
    lfsr_t  shift_a_next;
    lfsr_t  shift_b_next;
    byte_t  keystream;
    byte_t  scr_next;
    total_t ones_in_next;
    total_t ones_out_next;
    total_t bits_next;

    assign advance     = in_valid_reg && (!out_valid_reg || scrambled.ready);
    assign plain.ready = !in_valid_reg || advance;

    assign start_a = restart_reg ? seed_a_reg : shift_a_reg;
    assign start_b = restart_reg ? seed_b_reg : shift_b_reg;

    dls_keystream u_keystream (
        .start_a   (start_a),
        .start_b   (start_b),
        .keystream (keystream),
        .end_a     (shift_a_next),
        .end_b     (shift_b_next)
    );

    assign scr_next = data_reg ^ keystream;

    dls_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_ones_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .clear      (restart_reg),
        .inc        (popcount8(data_reg)),
        .total_next (ones_in_next)
    );

    dls_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_ones_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .clear      (restart_reg),
        .inc        (popcount8(scr_next)),
        .total_next (ones_out_next)
    );

    dls_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_bits (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .clear      (restart_reg),
        .inc        (pop_t'(BYTE_W)),
        .total_next (bits_next)
    );

    // seed registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg <= SEED_RESET;
            seed_b_reg <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SEED_A: seed_a_reg <= cfg_data;
                REG_SEED_B: seed_b_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // lfsr state moves on once per byte handed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_a_reg <= SEED_RESET;
            shift_b_reg <= SEED_RESET;
        end
        else if (advance)
        begin
            shift_a_reg <= shift_a_next;
            shift_b_reg <= shift_b_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (plain.ready)
        begin
            in_valid_reg <= plain.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (plain.valid && plain.ready)
        begin
            data_reg    <= plain.data_byte;
            restart_reg <= plain.restart;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (scrambled.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scr_reg      <= scr_next;
            ones_in_reg  <= ones_in_next;
            ones_out_reg <= ones_out_next;
            bits_reg     <= bits_next;
        end
    end

    assign scrambled.valid          = out_valid_reg;
    assign scrambled.scrambled_byte = scr_reg;
    assign scrambled.ones_in_total  = ones_in_reg;
    assign scrambled.ones_out_total = ones_out_reg;
    assign scrambled.bits_total     = bits_reg;

endmodule

### hdl/dls_keystream.sv
// eight keystream bits of the two combined lfsrs, and their states after the byte
// depends on dls_pkg
module dls_keystream
    import dls_pkg::*;
(
    input  lfsr_t start_a,
    input  lfsr_t start_b,
    output byte_t keystream,
    output lfsr_t end_a,
    output lfsr_t end_b
);

    always_comb
    begin
        lfsr_t a;
        lfsr_t b;
        logic  fa;
        logic  fb;
        a = start_a;
        b = start_b;
        keystream = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fa = fb_a(a);
            fb = fb_b(b);
            keystream[i] = fa ^ fb;
            a = {a[LFSR_W-2:0], fa};
            b = {b[LFSR_W-2:0], fb};
        end
        end_a = a;
        end_b = b;
    end

endmodule

### hdl/dls_sat_counter.sv
// saturating running counter with clear, and its next value clipped to 32 bits
// depends on dls_pkg
module dls_sat_counter
    import dls_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   clear,
    input  pop_t   inc,
    output total_t total_next
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH:0]   sum;

    assign base = clear ? '0 : count_reg;
    assign sum  = {1'b0, base} + (COUNT_WIDTH + 1)'(inc);
    assign count_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];

    generate
        if (COUNT_WIDTH > TOTAL_W)
        begin : g_clip
            assign total_next = (|count_next[COUNT_WIDTH-1:TOTAL_W]) ? '1
                                                                      : count_next[TOTAL_W-1:0];
        end
        else
        begin : g_ext
            assign total_next = TOTAL_W'(count_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (en)
        begin
            count_reg <= count_next;
        end
    end

endmodule

### hdl/dls_checker.sv
// port-level checks on the result channel of the scrambler, bound to the top level
// depends on dls_pkg and dual_lfsr_stream_scrambler
module dls_checker
    import dls_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   out_valid,
    input logic   out_ready,
    input byte_t  out_byte,
    input total_t ones_in,
    input total_t ones_out,
    input total_t bits
);

    // a stalled transfer keeps its byte and its bit total
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(bits))
        else $error("result changed while stalled");

    // every result covers at least one byte
    a_bits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bits != '0)
        else $error("bit total is zero on a result");

    // whole bytes only, except a saturated count, which ends in all ones
    a_bits_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bits[2:0] != 3'b111 |-> bits[2:0] == 3'b000)
        else $error("bit total not a multiple of eight");

    // ones can never outnumber bits
    a_ones_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ones_in <= bits && ones_out <= bits)
        else $error("ones total exceeds bit total");

endmodule

bind dual_lfsr_stream_scrambler dls_checker u_dls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (scrambled.valid),
    .out_ready (scrambled.ready),
    .out_byte  (scrambled.scrambled_byte),
    .ones_in   (scrambled.ones_in_total),
    .ones_out  (scrambled.ones_out_total),
    .bits      (scrambled.bits_total)
);
